// ----- hdl/tld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tld_pkg: shared types and constants of the tracking lock debouncer
// Mode and transition codes, register indexes, field widths and the
// configuration and result bundles passed between modules.
// ----------------------------------------------------------------------------
package tld_pkg;

  // Field widths
  localparam int FieldWidth      = 16;
  localparam int ModeWidth       = 2;
  localparam int TransWidth      = 2;
  localparam int CfgIndexWidth   = 3;
  localparam int InDataWidth     = 32;
  localparam int OutDataWidth    = 40;
  localparam int CountWidthDflt  = 16;

  // Channel modes
  localparam logic [ModeWidth-1:0] MODE_ACQ   = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_CONF  = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_TRACK = 2'd2;

  // Transition events
  localparam logic [TransWidth-1:0] TRANS_NONE      = 2'd0;
  localparam logic [TransWidth-1:0] TRANS_CONFIRMED = 2'd1;
  localparam logic [TransWidth-1:0] TRANS_TIMEOUT   = 2'd2;
  localparam logic [TransWidth-1:0] TRANS_LOST      = 2'd3;

  // Command codes
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Register indexes
  localparam logic [CfgIndexWidth-1:0] REG_CARRIER_THR = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_RATIO_TOL   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_CONFIRM     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_LOSS        = 3'd4;

  // Register reset values
  localparam logic [FieldWidth-1:0] CARRIER_THR_RST = 16'd26214;
  localparam logic [FieldWidth-1:0] RATIO_TOL_RST   = 16'd1024;
  localparam logic [FieldWidth-1:0] CONFIRM_RST     = 16'd10;
  localparam logic [FieldWidth-1:0] TIMEOUT_RST     = 16'd100;
  localparam logic [FieldWidth-1:0] LOSS_RST        = 16'd10;

  // 1.0 in Q4.12
  localparam logic [FieldWidth-1:0] RATIO_ONE = 16'd4096;

  typedef struct packed {
    logic signed [FieldWidth-1:0] carrier_threshold;
    logic [FieldWidth-1:0]        ratio_tolerance;
    logic [FieldWidth-1:0]        confirm_blocks;
    logic [FieldWidth-1:0]        timeout_blocks;
    logic [FieldWidth-1:0]        loss_blocks;
  } tld_cfg_t;

  typedef struct packed {
    logic [FieldWidth-1:0] loss_level;
    logic [FieldWidth-1:0] confirm_level;
    logic [TransWidth-1:0] transition;
    logic                  good_flag;
    logic [ModeWidth-1:0]  channel_mode;
  } tld_result_t;

endpackage
`default_nettype wire

// ----- hdl/tracking_lock_debouncer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tracking_lock_debouncer: lock state machine of one tracking channel
// Debounces per-block lock decisions into acquiring/confirming/tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the command (0 evaluate, 1 start
//   confirming), in_tdata carries carrier_lock and code_ratio. Every input
//   transaction yields exactly one output transaction with mode, good flag,
//   transition event and the confirm and loss counter levels.
//   Configuration writes go through cfg_valid/cfg_index/cfg_data and are
//   always ready; write them only while no transaction is in flight.
//   A result passes from the input register through the criteria and
//   counter update into the output register, which drives out_tvalid.
//   Throughput is one transaction per cycle while out_tready stays high;
//   a new input is taken while the previous result is still held.
//   When out_tready is low the result holds, the input stage fills and
//   in_tready falls; flow resumes without loss once out_tready returns.
//   Reset (rst_n low, synchronous) empties both stages, restores register
//   defaults and puts the channel in acquiring with all counters at zero.
// ----------------------------------------------------------------------------
module tracking_lock_debouncer #(
  parameter int COUNT_WIDTH = tld_pkg::CountWidthDflt
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [tld_pkg::InDataWidth-1:0]      in_tdata,  // [15:0] carrier_lock, [31:16] code_ratio
  input  wire logic                                 in_tuser,  // [0] cmd
  // Result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [tld_pkg::OutDataWidth-1:0]          out_tdata, // [1:0] channel_mode, [2] good_flag,
                                                               // [4:3] transition, [20:5] confirm_level,
                                                               // [36:21] loss_level, [39:37] zero
  // Configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tld_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire logic [tld_pkg::FieldWidth-1:0]       cfg_data
);

  localparam int ResWidth = $bits(tld_pkg::tld_result_t);

  tld_pkg::tld_cfg_t    cfg;
  tld_pkg::tld_result_t result;

  logic                                  s1_valid_r;
  logic                                  s1_cmd_r;
  logic signed [tld_pkg::FieldWidth-1:0] s1_carrier_r;
  logic [tld_pkg::FieldWidth-1:0]        s1_ratio_r;
  logic                                  out_valid_r;
  tld_pkg::tld_result_t                  out_res_r;
  logic                                  advance;

  tld_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage moves on when the output register is free or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r     <= in_tuser;
      s1_carrier_r <= in_tdata[tld_pkg::FieldWidth-1:0];
      s1_ratio_r   <= in_tdata[2*tld_pkg::FieldWidth-1:tld_pkg::FieldWidth];
    end
  end

  tld_lock_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .cmd          (s1_cmd_r),
    .carrier_lock (s1_carrier_r),
    .code_ratio   (s1_ratio_r),
    .cfg          (cfg),
    .result       (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tld_pkg::OutDataWidth-ResWidth){1'b0}}, out_res_r};

endmodule
`default_nettype wire

// ----- hdl/tld_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tld_cfg_regs: configuration register file
// Five 16-bit registers written through an indexed write channel.
// Writes to unknown indexes are accepted and dropped.
// ----------------------------------------------------------------------------
module tld_cfg_regs (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tld_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [tld_pkg::FieldWidth-1:0]        cfg_data,
  output tld_pkg::tld_cfg_t                          cfg
);

  tld_pkg::tld_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_threshold <= tld_pkg::CARRIER_THR_RST;
      cfg_r.ratio_tolerance   <= tld_pkg::RATIO_TOL_RST;
      cfg_r.confirm_blocks    <= tld_pkg::CONFIRM_RST;
      cfg_r.timeout_blocks    <= tld_pkg::TIMEOUT_RST;
      cfg_r.loss_blocks       <= tld_pkg::LOSS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tld_pkg::REG_CARRIER_THR: cfg_r.carrier_threshold <= cfg_data;
        tld_pkg::REG_RATIO_TOL:   cfg_r.ratio_tolerance   <= cfg_data;
        tld_pkg::REG_CONFIRM:     cfg_r.confirm_blocks    <= cfg_data;
        tld_pkg::REG_TIMEOUT:     cfg_r.timeout_blocks    <= cfg_data;
        tld_pkg::REG_LOSS:        cfg_r.loss_blocks       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tld_lock_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tld_lock_fsm: lock criteria and channel state machine
// Evaluates one block per step strobe, updates mode and the saturating
// confirm, loss and elapsed counters, and presents the step's result.
// ----------------------------------------------------------------------------
module tld_lock_fsm #(
  parameter int COUNT_WIDTH = tld_pkg::CountWidthDflt
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 step,
  input  wire logic                                 cmd,
  input  wire logic signed [tld_pkg::FieldWidth-1:0] carrier_lock,
  input  wire logic [tld_pkg::FieldWidth-1:0]       code_ratio,
  input  wire tld_pkg::tld_cfg_t                    cfg,
  output tld_pkg::tld_result_t                      result
);

  // Compare width covers both counters and 16-bit limits
  localparam int CmpWidth = (COUNT_WIDTH > tld_pkg::FieldWidth) ?
                            COUNT_WIDTH : tld_pkg::FieldWidth;

  logic [tld_pkg::ModeWidth-1:0] mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0]        confirm_r, confirm_nxt;
  logic [COUNT_WIDTH-1:0]        loss_r, loss_nxt;
  logic [COUNT_WIDTH-1:0]        elapsed_r, elapsed_nxt;

  logic [tld_pkg::FieldWidth-1:0] ratio_dist;
  logic                           good;
  logic [tld_pkg::TransWidth-1:0] trans;
  logic                           good_out;
  logic [CmpWidth-1:0]            confirm_ext;
  logic [CmpWidth-1:0]            loss_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_up(input logic [COUNT_WIDTH-1:0] c);
    sat_up = (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_down(input logic [COUNT_WIDTH-1:0] c);
    sat_down = (c == '0) ? c : c - 1'b1;
  endfunction

  // Lock criteria: carrier at or above threshold, ratio within tolerance of 1.0
  always_comb begin
    ratio_dist = (code_ratio >= tld_pkg::RATIO_ONE) ? code_ratio - tld_pkg::RATIO_ONE
                                                    : tld_pkg::RATIO_ONE - code_ratio;
    good = (carrier_lock >= cfg.carrier_threshold) &&
           (ratio_dist <= cfg.ratio_tolerance);
  end

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    confirm_nxt = confirm_r;
    loss_nxt    = loss_r;
    elapsed_nxt = elapsed_r;
    trans       = tld_pkg::TRANS_NONE;
    good_out    = good;
    if (cmd == tld_pkg::CMD_START) begin
      mode_nxt    = tld_pkg::MODE_CONF;
      confirm_nxt = '0;
      loss_nxt    = '0;
      elapsed_nxt = '0;
      good_out    = 1'b0;
    end else begin
      unique case (mode_r)
        tld_pkg::MODE_CONF: begin
          confirm_nxt = good ? sat_up(confirm_r) : sat_down(confirm_r);
          elapsed_nxt = sat_up(elapsed_r);
          // Confirmation wins over timeout
          if (CmpWidth'(confirm_nxt) >= CmpWidth'(cfg.confirm_blocks)) begin
            loss_nxt = '0;
            mode_nxt = tld_pkg::MODE_TRACK;
            trans    = tld_pkg::TRANS_CONFIRMED;
          end else if (CmpWidth'(elapsed_nxt) >= CmpWidth'(cfg.timeout_blocks)) begin
            mode_nxt = tld_pkg::MODE_ACQ;
            trans    = tld_pkg::TRANS_TIMEOUT;
          end
        end
        tld_pkg::MODE_TRACK: begin
          loss_nxt = good ? sat_down(loss_r) : sat_up(loss_r);
          if (CmpWidth'(loss_nxt) >= CmpWidth'(cfg.loss_blocks)) begin
            mode_nxt = tld_pkg::MODE_ACQ;
            trans    = tld_pkg::TRANS_LOST;
          end
        end
        default: ; // acquiring holds
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tld_pkg::MODE_ACQ;
      confirm_r <= '0;
      loss_r    <= '0;
      elapsed_r <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      confirm_r <= confirm_nxt;
      loss_r    <= loss_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Result: levels carry the low 16 bits of the counters
  always_comb begin
    confirm_ext          = CmpWidth'(confirm_nxt);
    loss_ext             = CmpWidth'(loss_nxt);
    result.channel_mode  = mode_nxt;
    result.good_flag     = good_out;
    result.transition    = trans;
    result.confirm_level = confirm_ext[tld_pkg::FieldWidth-1:0];
    result.loss_level    = loss_ext[tld_pkg::FieldWidth-1:0];
  end

endmodule
`default_nettype wire

// ----- hdl/tld_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tld_checker: port-level checks of the tracking lock debouncer
// Watches the result stream for handshake and mode/transition consistency.
// ----------------------------------------------------------------------------
module tld_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [tld_pkg::OutDataWidth-1:0]  out_tdata
);

  logic [tld_pkg::ModeWidth-1:0]  mode;
  logic [tld_pkg::TransWidth-1:0] trans;
  logic [tld_pkg::FieldWidth-1:0] loss_level;

  assign mode       = out_tdata[1:0];
  assign trans      = out_tdata[4:3];
  assign loss_level = out_tdata[36:21];

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Confirmation lands in tracking with the loss counter cleared
  a_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && trans == tld_pkg::TRANS_CONFIRMED |->
      mode == tld_pkg::MODE_TRACK && loss_level == '0)
    else $error("confirmed without entering tracking");

  // Timeout and loss of lock fall back to acquiring
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (trans == tld_pkg::TRANS_TIMEOUT || trans == tld_pkg::TRANS_LOST) |->
      mode == tld_pkg::MODE_ACQ)
    else $error("timeout or loss without returning to acquiring");

endmodule

bind tracking_lock_debouncer tld_checker u_tld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
